/* rtl/brp_pkg.sv */
`timescale 1ns / 1ps

package brp_pkg;

  localparam int unsigned HalfwordWidth = 16;
  localparam int unsigned AddrWidth     = 32;
  localparam int unsigned DeltaWidth    = 64;
  localparam int unsigned CfgDataWidth  = 64;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned OffsetWidth   = 12;
  localparam int unsigned TypeWidth     = 4;

  localparam logic [AddrWidth-1:0] HeaderBytes = 32'd8;
  localparam logic [AddrWidth-1:0] ByteCountSat = 32'hFFFF_FFFF;
  localparam logic [AddrWidth-1:0] ByteCountHigh = 32'hFFFF_FFFD;

  typedef enum logic [TypeWidth-1:0] {
    TYPE_SKIP   = 4'd0,
    TYPE_WORD32 = 4'd3,
    TYPE_WORD64 = 4'd10
  } entry_type_t;

  typedef enum logic [1:0] {
    ST_PATCH    = 2'd0,
    ST_DONE     = 2'd1,
    ST_BAD_TYPE = 2'd2,
    ST_BAD_SIZE = 2'd3
  } status_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DELTA       = 1'd0,
    REG_TABLE_BYTES = 1'd1
  } reg_index_t;

endpackage

/* rtl/brp_if.sv */
`timescale 1ns / 1ps

interface brp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] halfword;

  modport source (output valid, output halfword, input ready);
  modport sink   (input valid, input halfword, output ready);
endinterface

interface brp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] patch_offset;
  logic        patch_wide;

  modport source (output valid, output status, output patch_offset, output patch_wide,
                  input ready);
  modport sink   (input valid, input status, input patch_offset, input patch_wide,
                  output ready);
endinterface

/* rtl/base_relocation_parser.sv */
`timescale 1ns / 1ps

// Base relocation table parser. Halfwords of the table stream in on in_ch, one per
// transaction, and patch commands, end of table and error reports come out on out_ch
// (at most one result per halfword). Throughput is one halfword per cycle unless out_ch
// stalls a pending result: each halfword is captured in an input register, and then
// updates the parse state and loads the result register. Writing either configuration
// register restarts parsing; writes must only happen while the parser is idle. After an
// end or error status, input is drained with no results until the next configuration
// write.
module base_relocation_parser (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [brp_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [brp_pkg::CfgDataWidth-1:0]      cfg_data,
  brp_in_if.sink                                in_ch,
  brp_out_if.source                             out_ch
);
  import brp_pkg::*;

  // configuration
  logic [DeltaWidth-1:0] delta;
  logic [AddrWidth-1:0]  table_bytes;

  // input register
  logic                     hw_valid;
  logic [HalfwordWidth-1:0] hw;

  // parse state
  logic                 in_entries, in_entries_next;
  logic [1:0]           header_index, header_index_next;
  logic [AddrWidth-1:0] page_address, page_address_next;
  logic [AddrWidth-1:0] entry_bytes_left, entry_bytes_left_next;
  logic [AddrWidth-1:0] bytes_consumed, bytes_consumed_next;
  logic                 stopped, stopped_next;

  // result register
  logic                 res_valid;
  status_t              res_status;
  logic [AddrWidth-1:0] res_offset;
  logic                 res_wide;

  logic                 emit;
  status_t              emit_status;
  logic [AddrWidth-1:0] emit_offset;
  logic                 emit_wide;

  logic                 advance;
  logic [AddrWidth-1:0] size;
  logic [AddrWidth-1:0] bytes_counted;
  logic [AddrWidth-1:0] entry_addr;
  logic [TypeWidth-1:0] entry_type;

  assign advance     = hw_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !hw_valid || advance;

  assign size          = {hw, entry_bytes_left[HalfwordWidth-1:0]};
  assign bytes_counted = (bytes_consumed >= ByteCountHigh) ? ByteCountSat
                                                           : bytes_consumed + 32'd2;
  assign entry_addr    = page_address + {{(AddrWidth-OffsetWidth){1'b0}}, hw[OffsetWidth-1:0]};
  assign entry_type    = hw[HalfwordWidth-1 -: TypeWidth];

  always_comb begin
    in_entries_next       = in_entries;
    header_index_next     = header_index;
    page_address_next     = page_address;
    entry_bytes_left_next = entry_bytes_left;
    bytes_consumed_next   = bytes_consumed;
    stopped_next          = stopped;
    emit                  = 1'b0;
    emit_status           = ST_PATCH;
    emit_offset           = '0;
    emit_wide             = 1'b0;

    if (!stopped) begin
      if (!in_entries) begin
        case (header_index)
          2'd0: begin
            if (delta == '0 || bytes_consumed >= table_bytes) begin
              emit         = 1'b1;
              emit_status  = ST_DONE;
              stopped_next = 1'b1;
            end else begin
              page_address_next   = {{(AddrWidth-HalfwordWidth){1'b0}}, hw};
              header_index_next   = 2'd1;
              bytes_consumed_next = bytes_counted;
            end
          end
          2'd1: begin
            page_address_next   = {hw, page_address[HalfwordWidth-1:0]};
            header_index_next   = 2'd2;
            bytes_consumed_next = bytes_counted;
          end
          2'd2: begin
            entry_bytes_left_next = {{(AddrWidth-HalfwordWidth){1'b0}}, hw};
            header_index_next     = 2'd3;
            bytes_consumed_next   = bytes_counted;
          end
          default: begin
            bytes_consumed_next = bytes_counted;
            header_index_next   = 2'd0;
            if (size == '0) begin
              emit         = 1'b1;
              emit_status  = ST_DONE;
              stopped_next = 1'b1;
            end else if (size < HeaderBytes || size[0]) begin
              emit         = 1'b1;
              emit_status  = ST_BAD_SIZE;
              stopped_next = 1'b1;
            end else begin
              entry_bytes_left_next = size - HeaderBytes;
              // a block of exactly eight bytes has no entries
              in_entries_next       = (size != HeaderBytes);
            end
          end
        endcase
      end else begin
        bytes_consumed_next   = bytes_counted;
        entry_bytes_left_next = entry_bytes_left - 32'd2;
        if (entry_bytes_left == 32'd2) begin
          in_entries_next = 1'b0;
        end
        case (entry_type)
          TYPE_SKIP: begin
          end
          TYPE_WORD32: begin
            emit        = 1'b1;
            emit_offset = entry_addr;
          end
          TYPE_WORD64: begin
            emit        = 1'b1;
            emit_offset = entry_addr;
            emit_wide   = 1'b1;
          end
          default: begin
            emit         = 1'b1;
            emit_status  = ST_BAD_TYPE;
            stopped_next = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta            <= '0;
      table_bytes      <= '0;
      hw_valid         <= 1'b0;
      in_entries       <= 1'b0;
      header_index     <= '0;
      page_address     <= '0;
      entry_bytes_left <= '0;
      bytes_consumed   <= '0;
      stopped          <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        hw_valid <= in_ch.valid;
      end

      if (advance) begin
        res_valid <= emit;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_DELTA:       delta       <= cfg_data[DeltaWidth-1:0];
          REG_TABLE_BYTES: table_bytes <= cfg_data[AddrWidth-1:0];
          default: begin
          end
        endcase
        in_entries       <= 1'b0;
        header_index     <= '0;
        page_address     <= '0;
        entry_bytes_left <= '0;
        bytes_consumed   <= '0;
        stopped          <= 1'b0;
      end else if (advance) begin
        in_entries       <= in_entries_next;
        header_index     <= header_index_next;
        page_address     <= page_address_next;
        entry_bytes_left <= entry_bytes_left_next;
        bytes_consumed   <= bytes_consumed_next;
        stopped          <= stopped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      hw <= in_ch.halfword;
    end
    if (advance) begin
      res_status <= emit_status;
      res_offset <= emit_offset;
      res_wide   <= emit_wide;
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.status       = res_status;
  assign out_ch.patch_offset = res_offset;
  assign out_ch.patch_wide   = res_wide;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import brp_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic        wide;
  } patch_result_t;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandomItems = 650;
  localparam int unsigned LongHold = 150;
  localparam logic [3:0] TypeUnknown = 4'hF;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  brp_in_if in_ch();
  brp_out_if out_ch();

  base_relocation_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of registers and parse state
  logic [63:0] cfg_delta = '0;
  logic [31:0] cfg_table_bytes = '0;
  logic        prs_in_entries = 1'b0;
  logic [1:0]  prs_hdr_idx = '0;
  logic [31:0] prs_page = '0;
  logic [31:0] prs_left = '0;
  logic [31:0] prs_consumed = '0;
  logic        prs_stopped = 1'b0;

  patch_result_t expected_reports[$];
  int unsigned error_count = 0;
  int unsigned halfwords_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned max_gap = 11;
  int unsigned max_stall = 11;
  int unsigned hold_req = 0;

  always #6 clk = ~clk;

  function automatic void restart_parser();
    prs_in_entries = 1'b0;
    prs_hdr_idx = '0;
    prs_page = '0;
    prs_left = '0;
    prs_consumed = '0;
    prs_stopped = 1'b0;
  endfunction

  function automatic void count_halfword();
    if (prs_consumed >= ByteCountHigh) prs_consumed = ByteCountSat;
    else prs_consumed = prs_consumed + 32'd2;
  endfunction

  // returns 1 when the halfword produces a report
  function automatic bit parse_halfword(input logic [15:0] hw, output patch_result_t res);
    logic [31:0] size;
    logic [3:0] etype;
    res.status = ST_PATCH;
    res.offset = '0;
    res.wide = 1'b0;
    if (prs_stopped) return 1'b0;
    if (!prs_in_entries) begin
      case (prs_hdr_idx)
        2'd0: begin
          if (cfg_delta == '0 || prs_consumed >= cfg_table_bytes) begin
            prs_stopped = 1'b1;
            res.status = ST_DONE;
            return 1'b1;
          end
          prs_page = {16'h0, hw};
          prs_hdr_idx = 2'd1;
          count_halfword();
          return 1'b0;
        end
        2'd1: begin
          prs_page[31:16] = hw;
          prs_hdr_idx = 2'd2;
          count_halfword();
          return 1'b0;
        end
        2'd2: begin
          prs_left = {16'h0, hw};
          prs_hdr_idx = 2'd3;
          count_halfword();
          return 1'b0;
        end
        default: begin
          size = {hw, prs_left[15:0]};
          count_halfword();
          prs_hdr_idx = 2'd0;
          if (size == '0) begin
            prs_stopped = 1'b1;
            res.status = ST_DONE;
            return 1'b1;
          end
          if (size < HeaderBytes || size[0]) begin
            prs_stopped = 1'b1;
            res.status = ST_BAD_SIZE;
            return 1'b1;
          end
          prs_left = size - HeaderBytes;
          prs_in_entries = (prs_left != '0);
          return 1'b0;
        end
      endcase
    end
    etype = hw[15:12];
    count_halfword();
    prs_left = prs_left - 32'd2;
    if (prs_left == '0) prs_in_entries = 1'b0;
    res.offset = prs_page + {20'h0, hw[11:0]};
    if (etype == TYPE_SKIP) return 1'b0;
    if (etype == TYPE_WORD32) return 1'b1;
    if (etype == TYPE_WORD64) begin
      res.wide = 1'b1;
      return 1'b1;
    end
    res.offset = '0;
    res.status = ST_BAD_TYPE;
    prs_stopped = 1'b1;
    return 1'b1;
  endfunction

  function automatic void note_error(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("tb_top: mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
  endfunction

  task automatic send_halfword(input logic [15:0] hw);
    int unsigned gap;
    patch_result_t res;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.halfword <= hw;
    do @(posedge clk); while (!in_ch.ready);
    if (parse_halfword(hw, res)) expected_reports.push_back(res);
    halfwords_sent++;
  endtask

  task automatic send_header(input logic [31:0] page, input logic [31:0] size);
    send_halfword(page[15:0]);
    send_halfword(page[31:16]);
    send_halfword(size[15:0]);
    send_halfword(size[31:16]);
  endtask

  task automatic send_entry(input logic [3:0] etype, input logic [11:0] offset);
    send_halfword({etype, offset});
  endtask

  // drops valid and waits until every expected report is in
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    drain_results();
    // halfwords that make no report may still be in the pipeline
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_DELTA) cfg_delta = value;
    else cfg_table_bytes = value[31:0];
    restart_parser();
  endtask

  task automatic test_table_end();
    // after reset delta is zero: the first halfword ends the table
    send_halfword(16'hFFFF);
    send_halfword(16'h0000);
    write_reg(REG_DELTA, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_TABLE_BYTES, 64'h0);
    send_halfword(16'h5A5A);
  endtask

  task automatic test_patch_entries();
    // second block runs past the table length and is still parsed to its end
    write_reg(REG_TABLE_BYTES, {$urandom, 32'd18});
    send_header(32'hFFFF_FF00, 32'd14);
    send_entry(TYPE_WORD32, 12'hFFF);
    send_entry(TYPE_WORD64, 12'h000);
    send_entry(TYPE_SKIP, 12'hABC);
    send_header(32'h0000_1000, 32'd8);
    send_halfword(16'hFFFF);
  endtask

  task automatic test_bad_blocks();
    write_reg(REG_DELTA, 64'd1);
    send_header(32'h0001_2000, 32'h0001_0009);
    send_halfword(16'h3123);
    write_reg(REG_TABLE_BYTES, 64'hFFFF_FFFF);
    send_header(32'h7FFF_F000, 32'd6);
    write_reg(REG_DELTA, 64'h8000_0000_0000_0000);
    send_header(32'h0040_0000, 32'd12);
    send_entry(TYPE_WORD64, 12'h800);
    send_entry(TypeUnknown, 12'h7FF);
  endtask

  task automatic test_backpressure();
    write_reg(REG_TABLE_BYTES, 64'hFFFF_FFFF);
    max_gap = 0;
    hold_req = LongHold;
    send_header($urandom, 32'd88);
    repeat (20) send_entry($urandom_range(0, 1) ? TYPE_WORD64 : TYPE_WORD32, 12'($urandom));
    drain_results();
    repeat (20) send_entry($urandom_range(0, 1) ? TYPE_WORD64 : TYPE_WORD32, 12'($urandom));
    send_header($urandom, 32'd0);
    max_gap = 11;
  endtask

  task automatic run_random_table();
    int unsigned n_blocks;
    int unsigned n_ent[3];
    int unsigned total;
    int unsigned pick;
    logic [31:0] tbytes;
    logic [31:0] size;
    logic [3:0] etype;
    logic [63:0] dval;
    bit broken;
    n_blocks = $urandom_range(1, 3);
    total = 0;
    for (int b = 0; b < 3; b++) begin
      n_ent[b] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (b < n_blocks) total += 8 + 2 * n_ent[b];
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) dval = '0;
    else if (pick == 1) dval = '1;
    else dval = {$urandom, $urandom};
    if (pick < 2 || $urandom_range(0, 1)) write_reg(REG_DELTA, dval);
    pick = $urandom_range(0, 19);
    if (pick < 12) tbytes = total;
    else if (pick < 15) tbytes = total - 2 * $urandom_range(1, 4);
    else if (pick < 17) tbytes = 32'hFFFF_FFFF;
    else if (pick < 19) tbytes = $urandom;
    else tbytes = '0;
    write_reg(REG_TABLE_BYTES, {$urandom, tbytes});
    // some tables run with no idling on one or both sides
    pick = $urandom_range(0, 7);
    max_gap = (pick == 0 || pick == 1) ? 0 : 11;
    max_stall = (pick == 0 || pick == 2) ? 0 : 11;
    broken = 1'b0;
    for (int b = 0; b < n_blocks && !broken; b++) begin
      size = 8 + 2 * n_ent[b];
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        size = {$urandom} | 32'd1;
        broken = 1'b1;
      end else if (pick == 1) begin
        size = 2 * $urandom_range(0, 3);
        broken = 1'b1;
      end
      send_header($urandom, size);
      for (int e = 0; e < n_ent[b] && !broken; e++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) etype = TYPE_WORD32;
        else if (pick < 90) etype = TYPE_WORD64;
        else if (pick < 97) etype = TYPE_SKIP;
        else etype = 4'($urandom_range(0, 15));
        send_entry(etype, 12'($urandom));
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end
    send_header($urandom, 32'd0);
    repeat ($urandom_range(0, 2)) send_halfword(16'($urandom));
  endtask

  task automatic test_random_tables();
    while (halfwords_sent < RandomItems) run_random_table();
    max_gap = 11;
    max_stall = 11;
  endtask

  initial begin : result_receiver
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req != 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = $urandom_range(0, max_stall);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid && hold_req == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_reports
    patch_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        note_error("unexpected report status", '0, 32'(out_ch.status));
      end else begin
        want = expected_reports.pop_front();
        if (out_ch.status !== want.status)
          note_error("status", 32'(want.status), 32'(out_ch.status));
        if (out_ch.patch_offset !== want.offset)
          note_error("patch_offset", want.offset, out_ch.patch_offset);
        if (out_ch.patch_wide !== want.wide)
          note_error("patch_wide", 32'(want.wide), 32'(out_ch.patch_wide));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_DELTA;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.halfword = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_table_end();
    test_patch_entries();
    test_bad_blocks();
    test_backpressure();
    test_random_tables();
    drain_results();
    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0) note_error("reports left over", '0, expected_reports.size());
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/brp_pkg.sv
rtl/brp_if.sv
rtl/base_relocation_parser.sv
tb/tb_top.sv
